/* sv/bcd_time_digit_editor_unit_assert.svh */
// Assertion macros used by the BCD time digit editor top level.
`ifndef BCD_TIME_DIGIT_EDITOR_UNIT_ASSERT_SVH
`define BCD_TIME_DIGIT_EDITOR_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define BTDE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define BTDE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/btde_pkg.sv */
// Types and constants of the BCD time digit editor.
`timescale 1ns / 1ps
package btde_pkg;
	localparam int NUM_DIGITS = 12;

	typedef logic [3:0] digit_t;
	typedef logic [3:0] sel_t;
	typedef logic [NUM_DIGITS-1:0][3:0] digits_t;

	typedef enum logic [1:0] {
		OP_INC  = 2'd0,
		OP_DEC  = 2'd1,
		OP_LOAD = 2'd2,
		OP_NOP  = 2'd3
	} op_t;

	typedef struct packed {
		op_t    op;
		sel_t   sel;
		digit_t val;
	} edit_req_t;

	localparam sel_t SEL_YEAR_TENS   = 4'd0;
	localparam sel_t SEL_YEAR_ONES   = 4'd1;
	localparam sel_t SEL_MONTH_TENS  = 4'd2;
	localparam sel_t SEL_MONTH_ONES  = 4'd3;
	localparam sel_t SEL_DAY_TENS    = 4'd4;
	localparam sel_t SEL_DAY_ONES    = 4'd5;
	localparam sel_t SEL_HOUR_TENS   = 4'd6;
	localparam sel_t SEL_HOUR_ONES   = 4'd7;
	localparam sel_t SEL_MINUTE_TENS = 4'd8;
	localparam sel_t SEL_MINUTE_ONES = 4'd9;
	localparam sel_t SEL_SECOND_TENS = 4'd10;
	localparam sel_t SEL_SECOND_ONES = 4'd11;
	localparam sel_t SEL_LAST        = SEL_SECOND_ONES;

	localparam digit_t LIM_ONE   = 4'd1;
	localparam digit_t LIM_TWO   = 4'd2;
	localparam digit_t LIM_THREE = 4'd3;
	localparam digit_t LIM_FOUR  = 4'd4;
	localparam digit_t LIM_FIVE  = 4'd5;
	localparam digit_t LIM_NINE  = 4'd9;
endpackage

/* sv/btde_if.sv */
// Handshake interfaces for the edit command and digit result channels.
`timescale 1ns / 1ps
interface btde_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] operation;
	logic [3:0] digit_select;
	logic [3:0] digit_value;

	modport source (output valid, operation, digit_select, digit_value, input ready);
	modport sink (input valid, operation, digit_select, digit_value, output ready);
endinterface

interface btde_res_if;
	logic       valid;
	logic       ready;
	logic [3:0] year_tens;
	logic [3:0] year_ones;
	logic [3:0] month_tens;
	logic [3:0] month_ones;
	logic [3:0] day_tens;
	logic [3:0] day_ones;
	logic [3:0] hour_tens;
	logic [3:0] hour_ones;
	logic [3:0] minute_tens;
	logic [3:0] minute_ones;
	logic [3:0] second_tens;
	logic [3:0] second_ones;

	modport source (output valid, year_tens, year_ones, month_tens, month_ones, day_tens,
		day_ones, hour_tens, hour_ones, minute_tens, minute_ones, second_tens,
		second_ones, input ready);
	modport sink (input valid, year_tens, year_ones, month_tens, month_ones, day_tens,
		day_ones, hour_tens, hour_ones, minute_tens, minute_ones, second_tens,
		second_ones, output ready);
endinterface

/* sv/btde_in_stage.sv */
// Input register stage that captures one edit command per transfer.
`timescale 1ns / 1ps
module btde_in_stage (
	input  logic                 clk,
	input  logic                 arst_n,
	btde_cmd_if.sink             cmd,
	input  logic                 advance,
	output logic                 valid_s1,
	output btde_pkg::edit_req_t  req_s1
);
	logic take;

	assign cmd.ready = !valid_s1 || advance;
	assign take = cmd.valid && cmd.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			req_s1.op  <= btde_pkg::op_t'(cmd.operation);
			req_s1.sel <= cmd.digit_select;
			req_s1.val <= cmd.digit_value;
		end
	end
endmodule

/* sv/btde_digit_edit.sv */
// Next-digit logic: wrap limits, month tens gate and the selected digit update.
`timescale 1ns / 1ps
module btde_digit_edit (
	input  btde_pkg::digits_t    digits,
	input  btde_pkg::edit_req_t  req,
	output btde_pkg::digits_t    digits_next
);
	logic              hit;
	logic              gated;
	logic              change;
	btde_pkg::digit_t  cur;
	btde_pkg::digit_t  lim;
	btde_pkg::digit_t  upd;

	assign hit = (req.sel <= btde_pkg::SEL_LAST);
	assign cur = hit ? digits[req.sel] : '0;
	assign gated = (req.sel == btde_pkg::SEL_MONTH_TENS) &&
		(digits[btde_pkg::SEL_MONTH_ONES] >= btde_pkg::LIM_THREE);

	always_comb begin
		unique case (req.sel)
			btde_pkg::SEL_MONTH_TENS: lim = btde_pkg::LIM_ONE;
			btde_pkg::SEL_MONTH_ONES: begin
				lim = (digits[btde_pkg::SEL_MONTH_TENS] == '0) ?
					btde_pkg::LIM_NINE : btde_pkg::LIM_TWO;
			end
			btde_pkg::SEL_DAY_TENS: begin
				lim = (digits[btde_pkg::SEL_DAY_ONES] < btde_pkg::LIM_TWO) ?
					btde_pkg::LIM_THREE : btde_pkg::LIM_TWO;
			end
			btde_pkg::SEL_DAY_ONES: begin
				lim = (digits[btde_pkg::SEL_DAY_TENS] < btde_pkg::LIM_THREE) ?
					btde_pkg::LIM_NINE : btde_pkg::LIM_ONE;
			end
			btde_pkg::SEL_HOUR_TENS: begin
				lim = (digits[btde_pkg::SEL_HOUR_ONES] < btde_pkg::LIM_FIVE) ?
					btde_pkg::LIM_TWO : btde_pkg::LIM_ONE;
			end
			btde_pkg::SEL_HOUR_ONES: begin
				lim = (digits[btde_pkg::SEL_HOUR_TENS] < btde_pkg::LIM_TWO) ?
					btde_pkg::LIM_NINE : btde_pkg::LIM_FOUR;
			end
			btde_pkg::SEL_MINUTE_TENS, btde_pkg::SEL_SECOND_TENS: lim = btde_pkg::LIM_FIVE;
			default: lim = btde_pkg::LIM_NINE;
		endcase
	end

	always_comb begin
		unique case (req.op)
			btde_pkg::OP_INC:  upd = (cur == lim) ? '0 : cur + 4'd1;
			btde_pkg::OP_DEC:  upd = (cur == '0) ? lim : cur - 4'd1;
			btde_pkg::OP_LOAD: upd = req.val;
			default:           upd = cur;
		endcase
	end

	assign change = hit && !(gated && (req.op != btde_pkg::OP_LOAD));

	always_comb begin
		digits_next = digits;
		if (change) begin
			digits_next[req.sel] = upd;
		end
	end
endmodule

/* sv/bcd_time_digit_editor_unit.sv */
// Top level of the BCD date and time digit editor.
// Each command transfer on cmd increments, decrements or loads one of twelve BCD digits
// (year, month, day, hour, minute, second; tens then ones) or is a no-op, and yields one
// result transfer on res carrying all twelve digits after the edit. Commands are taken one
// per cycle unless res stalls: a command lands in the input register and its result is
// written into the digit register, the whole edit being done combinationally as it is
// written. While a result waits, the input register can still take one command if it is
// empty, after which cmd stalls until res takes the waiting result, so throughput stays
// one command per cycle unless res stalls. After reset all digits are zero.
`timescale 1ns / 1ps
`include "bcd_time_digit_editor_unit_assert.svh"
module bcd_time_digit_editor_unit (
	input  logic        clk,
	input  logic        arst_n,
	btde_cmd_if.sink    cmd,
	btde_res_if.source  res
);
	logic                 valid_s1;
	logic                 advance;
	logic                 res_valid_q;
	btde_pkg::edit_req_t  req_s1;
	btde_pkg::digits_t    digits_q;
	btde_pkg::digits_t    digits_next;

	assign advance = valid_s1 && (!res_valid_q || res.ready);

	btde_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.req_s1   (req_s1)
	);

	btde_digit_edit u_digit_edit (
		.digits      (digits_q),
		.req         (req_s1),
		.digits_next (digits_next)
	);

	// The digit register doubles as the result register: it only changes when a
	// new result is loaded, so it is stable while a result waits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digits_q    <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				digits_q    <= digits_next;
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign res.valid       = res_valid_q;
	assign res.year_tens   = digits_q[btde_pkg::SEL_YEAR_TENS];
	assign res.year_ones   = digits_q[btde_pkg::SEL_YEAR_ONES];
	assign res.month_tens  = digits_q[btde_pkg::SEL_MONTH_TENS];
	assign res.month_ones  = digits_q[btde_pkg::SEL_MONTH_ONES];
	assign res.day_tens    = digits_q[btde_pkg::SEL_DAY_TENS];
	assign res.day_ones    = digits_q[btde_pkg::SEL_DAY_ONES];
	assign res.hour_tens   = digits_q[btde_pkg::SEL_HOUR_TENS];
	assign res.hour_ones   = digits_q[btde_pkg::SEL_HOUR_ONES];
	assign res.minute_tens = digits_q[btde_pkg::SEL_MINUTE_TENS];
	assign res.minute_ones = digits_q[btde_pkg::SEL_MINUTE_ONES];
	assign res.second_tens = digits_q[btde_pkg::SEL_SECOND_TENS];
	assign res.second_ones = digits_q[btde_pkg::SEL_SECOND_ONES];

	`BTDE_ASSERT_NEXT(a_digits_hold, !advance, $stable(digits_q), "digits changed without an edit")
	`BTDE_ASSERT_NOW(a_accept_while_wait, res_valid_q && !res.ready && !valid_s1, cmd.ready, "input stalled with an empty input register")
	`BTDE_ASSERT_NEXT(a_load_second_ones, advance && req_s1.sel == btde_pkg::SEL_SECOND_ONES && req_s1.op == btde_pkg::OP_LOAD, digits_q[btde_pkg::SEL_SECOND_ONES] == $past(req_s1.val), "load did not store the value")
	`BTDE_ASSERT_NEXT(a_month_gate, advance && req_s1.sel == btde_pkg::SEL_MONTH_TENS && req_s1.op != btde_pkg::OP_LOAD && digits_q[btde_pkg::SEL_MONTH_ONES] >= btde_pkg::LIM_THREE, $stable(digits_q), "gated month tens changed")
	`BTDE_ASSERT_NEXT(a_result_follows, advance, res_valid_q, "edit without a result")
endmodule

/* test/bcd_time_digit_editor_unit_test.sv */
// Self-checking testbench for the BCD date and time digit editor top level.
`timescale 1ns / 1ps
module bcd_time_digit_editor_unit_test;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int LONG_HOLD = 60;
	localparam int PRINT_CAP = 40;

	logic clk;
	logic arst_n;

	btde_cmd_if cmd_ch ();
	btde_res_if res_ch ();

	bcd_time_digit_editor_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_ch),
		.res(res_ch)
	);

	btde_pkg::digits_t shadow_clock;
	btde_pkg::digits_t pending_digits[$];
	bit idle_on = 1'b1;
	int hold_request = 0;
	int error_count = 0;
	int edit_count = 0;
	int ignored_count = 0;
	int checked_count = 0;
	int quiet_cycles = 0;

	string digit_name[btde_pkg::NUM_DIGITS] = '{"year_tens", "year_ones", "month_tens",
		"month_ones", "day_tens", "day_ones", "hour_tens", "hour_ones", "minute_tens",
		"minute_ones", "second_tens", "second_ones"};

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic btde_pkg::digit_t wrap_point(btde_pkg::sel_t sel);
		case (sel)
			btde_pkg::SEL_MONTH_TENS: return btde_pkg::LIM_ONE;
			btde_pkg::SEL_MONTH_ONES:
				return (shadow_clock[btde_pkg::SEL_MONTH_TENS] == 4'd0) ?
					btde_pkg::LIM_NINE : btde_pkg::LIM_TWO;
			btde_pkg::SEL_DAY_TENS:
				return (shadow_clock[btde_pkg::SEL_DAY_ONES] < btde_pkg::LIM_TWO) ?
					btde_pkg::LIM_THREE : btde_pkg::LIM_TWO;
			btde_pkg::SEL_DAY_ONES:
				return (shadow_clock[btde_pkg::SEL_DAY_TENS] < btde_pkg::LIM_THREE) ?
					btde_pkg::LIM_NINE : btde_pkg::LIM_ONE;
			btde_pkg::SEL_HOUR_TENS:
				return (shadow_clock[btde_pkg::SEL_HOUR_ONES] < btde_pkg::LIM_FIVE) ?
					btde_pkg::LIM_TWO : btde_pkg::LIM_ONE;
			btde_pkg::SEL_HOUR_ONES:
				return (shadow_clock[btde_pkg::SEL_HOUR_TENS] < btde_pkg::LIM_TWO) ?
					btde_pkg::LIM_NINE : btde_pkg::LIM_FOUR;
			btde_pkg::SEL_MINUTE_TENS, btde_pkg::SEL_SECOND_TENS: return btde_pkg::LIM_FIVE;
			default: return btde_pkg::LIM_NINE;
		endcase
	endfunction

	// Wrap tests compare for equality only, so a digit above its bound keeps counting.
	function automatic void apply_edit(btde_pkg::op_t op, btde_pkg::sel_t sel,
		btde_pkg::digit_t val);
		btde_pkg::digit_t cur;
		btde_pkg::digit_t bound;
		logic frozen;
		if (sel > btde_pkg::SEL_LAST)
			return;
		cur = shadow_clock[sel];
		bound = wrap_point(sel);
		frozen = (sel == btde_pkg::SEL_MONTH_TENS) &&
			(shadow_clock[btde_pkg::SEL_MONTH_ONES] >= btde_pkg::LIM_THREE);
		case (op)
			btde_pkg::OP_INC: if (!frozen) shadow_clock[sel] = (cur == bound) ? 4'd0 : cur + 4'd1;
			btde_pkg::OP_DEC: if (!frozen) shadow_clock[sel] = (cur == 4'd0) ? bound : cur - 4'd1;
			btde_pkg::OP_LOAD: shadow_clock[sel] = val;
			default: ;
		endcase
	endfunction

	task automatic report_mismatch(string msg);
		if (error_count < PRINT_CAP)
			$display("%0t ns: %s", $time, msg);
		error_count++;
	endtask

	task automatic send_edit(btde_pkg::op_t op, btde_pkg::sel_t sel, btde_pkg::digit_t val);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			cmd_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.operation <= op;
		cmd_ch.digit_select <= sel;
		cmd_ch.digit_value <= val;
		do @(posedge clk); while (!cmd_ch.ready);
		apply_edit(op, sel, val);
		pending_digits.push_back(shadow_clock);
		if (op == btde_pkg::OP_NOP || sel > btde_pkg::SEL_LAST)
			ignored_count++;
		else
			edit_count++;
	endtask

	initial begin : result_receiver
		forever begin
			if (hold_request > 0) begin
				res_ch.ready <= 1'b0;
				repeat (hold_request) @(posedge clk);
				hold_request = 0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				res_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end else begin
				res_ch.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	always @(posedge clk) begin : result_check
		btde_pkg::digits_t got;
		btde_pkg::digits_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got = {res_ch.second_ones, res_ch.second_tens, res_ch.minute_ones,
				res_ch.minute_tens, res_ch.hour_ones, res_ch.hour_tens, res_ch.day_ones,
				res_ch.day_tens, res_ch.month_ones, res_ch.month_tens, res_ch.year_ones,
				res_ch.year_tens};
			if (pending_digits.size() == 0) begin
				report_mismatch("result transfer with no expected digits waiting");
			end else begin
				want = pending_digits.pop_front();
				checked_count++;
				for (int k = 0; k < btde_pkg::NUM_DIGITS; k++) begin
					if (got[k] !== want[k])
						report_mismatch($sformatf("%s: got %0d, expected %0d",
							digit_name[k], got[k], want[k]));
				end
			end
		end
	end

	always @(posedge clk) begin : watchdog
		if (!arst_n || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
			quiet_cycles = 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles", quiet_cycles);
			$display("bcd_time_digit_editor_unit_test: FAIL");
			$finish;
		end else begin
			quiet_cycles++;
		end
	end

	task automatic test_reset_state();
		send_edit(btde_pkg::OP_NOP, btde_pkg::SEL_YEAR_TENS, 4'd0);
	endtask

	task automatic test_plain_wraps();
		send_edit(btde_pkg::OP_DEC, btde_pkg::SEL_YEAR_TENS, 4'd0);
		send_edit(btde_pkg::OP_INC, btde_pkg::SEL_YEAR_TENS, 4'd0);
		send_edit(btde_pkg::OP_DEC, btde_pkg::SEL_MINUTE_TENS, 4'd0);
		send_edit(btde_pkg::OP_DEC, btde_pkg::SEL_SECOND_TENS, 4'd0);
		send_edit(btde_pkg::OP_DEC, btde_pkg::SEL_SECOND_ONES, 4'd0);
	endtask

	task automatic test_month_rules();
		send_edit(btde_pkg::OP_DEC, btde_pkg::SEL_MONTH_TENS, 4'd0);
		send_edit(btde_pkg::OP_DEC, btde_pkg::SEL_MONTH_ONES, 4'd0);
		send_edit(btde_pkg::OP_INC, btde_pkg::SEL_MONTH_TENS, 4'd0);
		send_edit(btde_pkg::OP_LOAD, btde_pkg::SEL_MONTH_ONES, 4'd9);
		send_edit(btde_pkg::OP_INC, btde_pkg::SEL_MONTH_TENS, 4'd0);
		send_edit(btde_pkg::OP_DEC, btde_pkg::SEL_MONTH_TENS, 4'd0);
		send_edit(btde_pkg::OP_INC, btde_pkg::SEL_MONTH_ONES, 4'd0);
	endtask

	task automatic test_day_rules();
		send_edit(btde_pkg::OP_LOAD, btde_pkg::SEL_DAY_ONES, 4'd1);
		send_edit(btde_pkg::OP_DEC, btde_pkg::SEL_DAY_TENS, 4'd0);
		send_edit(btde_pkg::OP_INC, btde_pkg::SEL_DAY_ONES, 4'd0);
		send_edit(btde_pkg::OP_DEC, btde_pkg::SEL_DAY_ONES, 4'd0);
		send_edit(btde_pkg::OP_LOAD, btde_pkg::SEL_DAY_ONES, 4'd5);
		send_edit(btde_pkg::OP_INC, btde_pkg::SEL_DAY_TENS, 4'd0);
	endtask

	task automatic test_hour_rules();
		send_edit(btde_pkg::OP_LOAD, btde_pkg::SEL_HOUR_ONES, 4'd5);
		send_edit(btde_pkg::OP_DEC, btde_pkg::SEL_HOUR_TENS, 4'd0);
		send_edit(btde_pkg::OP_LOAD, btde_pkg::SEL_HOUR_ONES, 4'd4);
		send_edit(btde_pkg::OP_INC, btde_pkg::SEL_HOUR_TENS, 4'd0);
		send_edit(btde_pkg::OP_INC, btde_pkg::SEL_HOUR_ONES, 4'd0);
	endtask

	task automatic test_out_of_range();
		send_edit(btde_pkg::OP_LOAD, btde_pkg::SEL_SECOND_ONES, 4'hF);
		send_edit(btde_pkg::OP_INC, btde_pkg::SEL_SECOND_ONES, 4'h0);
		send_edit(btde_pkg::OP_LOAD, btde_pkg::SEL_SECOND_TENS, 4'hC);
		send_edit(btde_pkg::OP_DEC, btde_pkg::SEL_SECOND_TENS, 4'hF);
		send_edit(btde_pkg::OP_NOP, btde_pkg::SEL_YEAR_TENS, 4'hF);
		send_edit(btde_pkg::OP_INC, btde_pkg::sel_t'(4'hF), 4'hF);
	endtask

	// Most edits are legal and lean on the coupled month, day and hour digits.
	task automatic test_random_edits(int count);
		int done;
		btde_pkg::op_t op;
		btde_pkg::sel_t sel;
		btde_pkg::digit_t val;
		done = 0;
		while (done < count) begin
			if ($urandom_range(0, 9) < 8) begin
				op = btde_pkg::op_t'($urandom_range(0, 2));
				sel = $urandom_range(0, 1) ? btde_pkg::sel_t'($urandom_range(2, 7))
					: btde_pkg::sel_t'($urandom_range(0, 11));
				val = btde_pkg::digit_t'($urandom_range(0, 9));
			end else begin
				op = btde_pkg::op_t'($urandom_range(0, 3));
				sel = btde_pkg::sel_t'($urandom_range(0, 15));
				val = btde_pkg::digit_t'($urandom_range(0, 15));
			end
			done++;
			send_edit(op, sel, val);
		end
	endtask

	task automatic test_output_stall();
		idle_on = 1'b0;
		hold_request = LONG_HOLD;
		test_random_edits(20);
		idle_on = 1'b1;
	endtask

	initial begin : main_sequence
		arst_n <= 1'b0;
		cmd_ch.valid <= 1'b0;
		cmd_ch.operation <= btde_pkg::OP_NOP;
		cmd_ch.digit_select <= btde_pkg::SEL_YEAR_TENS;
		cmd_ch.digit_value <= 4'd0;
		shadow_clock = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_plain_wraps();
		test_month_rules();
		test_day_rules();
		test_hour_rules();
		test_out_of_range();
		test_random_edits(1100);
		test_output_stall();
		test_random_edits(400);
		idle_on = 1'b0;
		test_random_edits(400);

		cmd_ch.valid <= 1'b0;
		while (pending_digits.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("Sent %0d digit edits and %0d ignored commands; checked %0d results.",
			edit_count, ignored_count, checked_count);
		$display("Covered wraps, sibling-dependent bounds, the month gate and a long stall.");
		if (error_count == 0)
			$display("bcd_time_digit_editor_unit_test: PASS");
		else
			$display("bcd_time_digit_editor_unit_test: FAIL");
		$finish;
	end
endmodule
